>>> rtl/core/nnc_pkg.sv
// ----------------------------------------------------------------------------
// Nearest neighbor classifier package
// Shared widths, codes, payload types and state encoding of the classifier.
// ----------------------------------------------------------------------------
package nnc_pkg;

	// Field widths of the item payloads.
	localparam int MODE_W  = 2;
	localparam int ELEM_W  = 16;
	localparam int LABEL_W = 16;
	localparam int FLEN_W  = 7;
	localparam int DIST_W  = 38;
	localparam int SQ_W    = 2 * ELEM_W;

	// Default sizes of the reference table.
	localparam int MAX_ENTRIES_DEF = 256;
	localparam int MAX_DIM_DEF     = 64;

	// Reset value of the feature length register.
	localparam logic [FLEN_W-1:0] FEATURE_LENGTH_RESET = 7'd64;

	// Saturated distance value.
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// Item mode codes.
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

	// Input item payload.
	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic signed [ELEM_W-1:0] element_value;
		logic [LABEL_W-1:0] class_label;
	} nnc_in_t;

	// Result item payload.
	typedef struct packed {
		logic               found;
		logic [LABEL_W-1:0] nearest_label;
		logic [DIST_W-1:0]  best_distance_sq;
	} nnc_out_t;

	// Control that travels with one element read from the stores.
	typedef struct packed {
		logic valid;
		logic last_elem;
	} elem_ctl_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_LABEL,
		ST_DONE
	} state_t;

endpackage

>>> rtl/core/nnc_if.sv
// ----------------------------------------------------------------------------
// Nearest neighbor classifier channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface nnc_in_if;
	import nnc_pkg::*;

	logic    valid;
	logic    ready;
	nnc_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nnc_out_if;
	import nnc_pkg::*;

	logic     valid;
	logic     ready;
	nnc_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/nnc_dist_acc.sv
// ----------------------------------------------------------------------------
// Nearest neighbor distance accumulator
// Takes element pairs from the stores, squares their difference, sums them
// per entry with saturation and keeps the first entry with the smallest sum.
// ----------------------------------------------------------------------------
module nnc_dist_acc #(
	parameter int MAX_ENTRIES = nnc_pkg::MAX_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  nnc_pkg::elem_ctl_t            ctl_s1,
	input  logic [nnc_pkg::ELEM_W-1:0]    ref_s1,
	input  logic [nnc_pkg::ELEM_W-1:0]    qry_s1,
	output logic                          busy,
	output logic                          best_found,
	output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] best_entry,
	output logic [nnc_pkg::DIST_W-1:0]    best_dist
);
	import nnc_pkg::*;

	localparam int ENT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

	elem_ctl_t               ctl_s2, ctl_s3;
	logic [ELEM_W-1:0]       mag_s2;
	logic [SQ_W-1:0]         sq_s3;
	logic signed [ELEM_W:0]  diff;
	logic [DIST_W-1:0]       acc_q;
	logic [DIST_W:0]         sum;
	logic [DIST_W-1:0]       sum_sat;
	logic [ENT_W-1:0]        ent_q;
	logic                    best_found_q;
	logic [ENT_W-1:0]        best_entry_q;
	logic [DIST_W-1:0]       best_dist_q;

	// Difference of the two signed elements, one bit wider than an element.
	always_comb begin
		diff = {qry_s1[ELEM_W-1], qry_s1} - {ref_s1[ELEM_W-1], ref_s1};
	end

	// Control stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	// Magnitude, then square.
	always_ff @(posedge clk) begin
		mag_s2 <= diff[ELEM_W] ? ELEM_W'(-diff) : ELEM_W'(diff);
		sq_s3  <= mag_s2 * mag_s2;
	end

	// Saturating sum of the running total and the new square.
	always_comb begin
		sum     = {1'b0, acc_q} + (DIST_W + 1)'(sq_s3);
		sum_sat = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
	end

	// Per-entry total and best-so-far tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			ent_q        <= '0;
			best_found_q <= 1'b0;
			best_entry_q <= '0;
			best_dist_q  <= '0;
		end else if (start) begin
			acc_q        <= '0;
			ent_q        <= '0;
			best_found_q <= 1'b0;
		end else if (ctl_s3.valid) begin
			if (ctl_s3.last_elem) begin
				acc_q <= '0;
				ent_q <= ent_q + ENT_W'(1);
				if (!best_found_q || (sum_sat < best_dist_q)) begin
					best_found_q <= 1'b1;
					best_entry_q <= ent_q;
					best_dist_q  <= sum_sat;
				end
			end else begin
				acc_q <= sum_sat;
			end
		end
	end

	assign busy       = ctl_s1.valid | ctl_s2.valid | ctl_s3.valid;
	assign best_found = best_found_q;
	assign best_entry = best_entry_q;
	assign best_dist  = best_dist_q;

	// A new search only starts with an empty pipeline.
	a_start_empty: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("search started while elements were in flight");

	// The best match is only forgotten when a new search starts.
	a_found_kept: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(best_found_q) |-> $past(start))
		else $error("best match lost outside a search start");

	// A first match always comes from a finished entry.
	a_found_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(best_found_q) |-> $past(ctl_s3.valid && ctl_s3.last_elem))
		else $error("best match set without an entry ending");

endmodule

>>> rtl/core/nearest_neighbour_classifier.sv
// ----------------------------------------------------------------------------
// Nearest neighbor classifier
// One-nearest-neighbor search by squared distance over a stored table.
// ----------------------------------------------------------------------------
// Usage: every item on the query channel carries a mode, one signed Q8.8
// element and a label. Clear empties the table, load writes one element of
// the next reference vector (the label is stored at its last element), and
// query writes one element of the query vector. Loads into a full table are
// dropped. Only the last query element gives a result item on the result
// channel: the first stored entry with the smallest sum of squared
// differences, or found low when the table is empty.
// Clear, load, unused codes and non-last query elements are taken in the idle
// state and leave it idle. A last query element starts a search: the walk
// reads one element pair a cycle from the reference memory and the query
// buffer, the square and sum pipeline drains, the winner's label is read and
// the output register is loaded; an empty table goes straight to the load.
// feature_length is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// Reset empties the table, zeroes the element position and sets the length
// to 64; no clearing pass runs. A stalled result is held in the output
// register while further items are accepted; a new result waits for it.
// ----------------------------------------------------------------------------
module nearest_neighbour_classifier #(
	parameter int MAX_ENTRIES = nnc_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_DIM     = nnc_pkg::MAX_DIM_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [nnc_pkg::FLEN_W-1:0] cfg_wdata,
	nnc_in_if.sink                     query,
	nnc_out_if.source                  result
);
	import nnc_pkg::*;

	localparam int ENT_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int LEN_W  = $clog2(MAX_DIM + 1) + 1;
	localparam int REF_AW = ENT_W + DIM_W;

	// Stores.
	logic [ELEM_W-1:0]  ref_mem [0:(1 << REF_AW)-1];
	logic [LABEL_W-1:0] label_mem [0:(1 << ENT_W)-1];
	logic [ELEM_W-1:0]  qry_mem [0:(1 << DIM_W)-1];

	state_t             state_q, state_d;
	logic [FLEN_W-1:0]  feature_len_q;
	logic [CNT_W-1:0]   entry_cnt_q;
	logic [DIM_W-1:0]   elem_idx_q;
	logic [ENT_W-1:0]   walk_ent_q;
	logic [DIM_W-1:0]   walk_idx_q;

	logic [LEN_W-1:0]   act_len;
	logic [DIM_W-1:0]   last_idx;
	logic [DIM_W-1:0]   cur_idx;
	logic               is_last;
	logic               accept;
	logic               table_full;
	logic               in_ready;
	logic               start;
	logic               walk_en;
	logic               walk_entry_end;
	logic               walk_end;
	logic               out_load;

	elem_ctl_t          ctl_s1;
	logic [ELEM_W-1:0]  ref_rd_s1;
	logic [ELEM_W-1:0]  qry_rd_s1;
	logic [LABEL_W-1:0] lbl_rd_q;

	logic               busy;
	logic               best_found;
	logic [ENT_W-1:0]   best_entry;
	logic [DIST_W-1:0]  best_dist;

	logic               out_valid_q;
	nnc_out_t           out_data_q;

	// Active vector length, with zero taken as one and the top clipped.
	always_comb begin
		if (feature_len_q == '0) begin
			act_len = LEN_W'(1);
		end else if (int'(feature_len_q) > MAX_DIM) begin
			act_len = LEN_W'(MAX_DIM);
		end else begin
			act_len = LEN_W'(feature_len_q);
		end
		last_idx = DIM_W'(act_len - LEN_W'(1));
		cur_idx  = (LEN_W'(elem_idx_q) >= act_len) ? last_idx : elem_idx_q;
		is_last  = (cur_idx == last_idx);
	end

	assign accept     = query.valid & in_ready;
	assign table_full = (entry_cnt_q >= CNT_W'(MAX_ENTRIES));

	// Walk position decode.
	assign walk_entry_end = (walk_idx_q == last_idx);
	assign walk_end       = walk_entry_end &&
		((CNT_W'(walk_ent_q) + CNT_W'(1)) == entry_cnt_q);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer next state and strobes.
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		start    = 1'b0;
		walk_en  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (accept && (query.data.mode == MODE_QUERY) && is_last) begin
					start   = 1'b1;
					state_d = (entry_cnt_q == '0) ? ST_DONE : ST_WALK;
				end
			end
			ST_WALK: begin
				walk_en = 1'b1;
				if (walk_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!busy) begin
					state_d = ST_LABEL;
				end
			end
			ST_LABEL: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || result.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feature_len_q <= FEATURE_LENGTH_RESET;
		end else if (cfg_we) begin
			feature_len_q <= cfg_wdata;
		end
	end

	// Table fill count and element position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_cnt_q <= '0;
			elem_idx_q  <= '0;
		end else if (accept) begin
			case (query.data.mode)
				MODE_CLEAR: begin
					entry_cnt_q <= '0;
					elem_idx_q  <= '0;
				end
				MODE_LOAD: begin
					if (!table_full && is_last) begin
						entry_cnt_q <= entry_cnt_q + CNT_W'(1);
					end
					elem_idx_q <= is_last ? '0 : cur_idx + DIM_W'(1);
				end
				MODE_QUERY: begin
					elem_idx_q <= is_last ? '0 : cur_idx + DIM_W'(1);
				end
				default: begin
					elem_idx_q <= elem_idx_q;
				end
			endcase
		end
	end

	// Walk address counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_ent_q <= '0;
			walk_idx_q <= '0;
		end else if (start) begin
			walk_ent_q <= '0;
			walk_idx_q <= '0;
		end else if (walk_en) begin
			if (walk_entry_end) begin
				walk_idx_q <= '0;
				walk_ent_q <= walk_ent_q + ENT_W'(1);
			end else begin
				walk_idx_q <= walk_idx_q + DIM_W'(1);
			end
		end
	end

	// Reference memory: written by loads, read by the walk.
	always_ff @(posedge clk) begin
		if (accept && (query.data.mode == MODE_LOAD) && !table_full) begin
			ref_mem[{entry_cnt_q[ENT_W-1:0], cur_idx}] <= query.data.element_value;
		end
		ref_rd_s1 <= ref_mem[{walk_ent_q, walk_idx_q}];
	end

	// Label memory: written at the last load element, read for the winner.
	always_ff @(posedge clk) begin
		if (accept && (query.data.mode == MODE_LOAD) && !table_full && is_last) begin
			label_mem[entry_cnt_q[ENT_W-1:0]] <= query.data.class_label;
		end
		lbl_rd_q <= label_mem[best_entry];
	end

	// Query buffer: written by query elements, read by the walk.
	always_ff @(posedge clk) begin
		if (accept && (query.data.mode == MODE_QUERY)) begin
			qry_mem[cur_idx] <= query.data.element_value;
		end
		qry_rd_s1 <= qry_mem[walk_idx_q];
	end

	// Control that lines up with the registered memory reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid     <= walk_en;
			ctl_s1.last_elem <= walk_entry_end;
		end
	end

	nnc_dist_acc #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dist_acc (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.ctl_s1     (ctl_s1),
		.ref_s1     (ref_rd_s1),
		.qry_s1     (qry_rd_s1),
		.busy       (busy),
		.best_found (best_found),
		.best_entry (best_entry),
		.best_dist  (best_dist)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.found            <= best_found;
			out_data_q.nearest_label    <= best_found ? lbl_rd_q : '0;
			out_data_q.best_distance_sq <= best_found ? best_dist : '0;
		end
	end

	assign query.ready  = in_ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;

	// The fill count never passes the table size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond table size");

	// The walk only reads entries that hold a vector.
	a_walk_valid: assert property (@(posedge clk) disable iff (!arst_n)
		walk_en |-> (CNT_W'(walk_ent_q) < entry_cnt_q))
		else $error("walk reads an empty entry");

	// Finishing a search always presents a result.
	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("search finished without a result");

	// A search with a non-empty table only finishes with a match.
	a_label_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LABEL) |-> best_found)
		else $error("walk over a filled table found no match");

endmodule

>>> tb/nearest_neighbour_classifier_tb.sv
// ----------------------------------------------------------------------------
// Nearest neighbor classifier testbench
// Drives load, query, clear and unused items into the classifier and checks
// every result item against a predictor with its own copy of the reference
// table, query buffer and length register; typed directed rows carry their
// own expected result. A short directed table comes first, then random
// phases at several feature lengths, one filling the table to capacity.
// ----------------------------------------------------------------------------
module nearest_neighbour_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nnc_pkg::*;

	localparam int MAX_ENTRIES = MAX_ENTRIES_DEF;
	localparam int MAX_DIM     = MAX_DIM_DEF;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_CYCLES = 200;

	// One row of the directed table: a register write or one input item.
	typedef struct {
		bit                  is_cfg;
		logic [FLEN_W-1:0]   flen;
		nnc_in_t             item;
		bit                  typed;
		nnc_out_t            want;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [FLEN_W-1:0] cfg_wdata;

	nnc_in_if  query_ch ();
	nnc_out_if result_ch ();

	nearest_neighbour_classifier uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.query     (query_ch),
		.result    (result_ch)
	);

	// Predictor copy of the block state.
	logic [ELEM_W-1:0]  table_elems   [MAX_ENTRIES*MAX_DIM];
	bit                 table_written [MAX_ENTRIES*MAX_DIM];
	logic [LABEL_W-1:0] table_labels  [MAX_ENTRIES];
	logic [ELEM_W-1:0]  probe_elems   [MAX_DIM];
	bit                 probe_written [MAX_DIM];
	int                 table_count;
	int                 vec_pos;
	logic [FLEN_W-1:0]  feature_len;

	// Results still owed by the block, oldest first.
	nnc_out_t pending_results [$];
	int       mismatch_count;
	bit       idle_on;
	bit       hold_request;

	stim_row_t directed [];

	// Clock: 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Effective vector length, with out-of-range register values folded in.
	function automatic int active_len();
		if (feature_len == 0)
			return 1;
		if (feature_len > MAX_DIM)
			return MAX_DIM;
		return feature_len;
	endfunction

	// Updates the predicted state for one accepted item and reports whether it
	// produces a result item.
	function automatic bit classify_item(input nnc_in_t it, output nnc_out_t res);
		int len;
		int pos;
		int e;
		int i;
		bit last;
		bit hit;
		longint signed d;
		longint unsigned acc;
		longint unsigned best;
		logic [LABEL_W-1:0] best_lbl;
		res = '0;
		len = active_len();
		if (it.mode == MODE_CLEAR) begin
			table_count = 0;
			vec_pos = 0;
			return 1'b0;
		end
		if (it.mode == MODE_UNUSED)
			return 1'b0;
		pos = (vec_pos >= len) ? len - 1 : vec_pos;
		last = (pos == len - 1);
		if (it.mode == MODE_LOAD) begin
			// A full table drops the element but the position still advances.
			if (table_count < MAX_ENTRIES) begin
				table_elems[table_count*MAX_DIM + pos] = it.element_value;
				table_written[table_count*MAX_DIM + pos] = 1'b1;
				if (last) begin
					table_labels[table_count] = it.class_label;
					table_count++;
				end
			end
			vec_pos = last ? 0 : pos + 1;
			return 1'b0;
		end
		probe_elems[pos] = it.element_value;
		probe_written[pos] = 1'b1;
		if (!last) begin
			vec_pos = pos + 1;
			return 1'b0;
		end
		vec_pos = 0;
		hit = 1'b0;
		best = 0;
		best_lbl = '0;
		// Strict less-than keeps the earliest entry on a tie.
		for (e = 0; e < table_count; e++) begin
			acc = 0;
			for (i = 0; i < len; i++) begin
				d = longint'($signed(probe_elems[i])) -
					longint'($signed(table_elems[e*MAX_DIM + i]));
				acc += longint'(d * d);
			end
			if (acc > DIST_MAX)
				acc = DIST_MAX;
			if (!hit || acc < best) begin
				hit = 1'b1;
				best = acc;
				best_lbl = table_labels[e];
			end
		end
		res.found = hit;
		res.nearest_label = best_lbl;
		res.best_distance_sq = best[DIST_W-1:0];
		return 1'b1;
	endfunction

	// True when this item would end a query that reads a store location
	// never written since reset.
	function automatic bit reads_unwritten(input nnc_in_t it);
		int len;
		int pos;
		int e;
		int i;
		if (it.mode != MODE_QUERY || table_count == 0)
			return 1'b0;
		len = active_len();
		pos = (vec_pos >= len) ? len - 1 : vec_pos;
		if (pos != len - 1)
			return 1'b0;
		for (i = 0; i < len; i++)
			if (i != pos && !probe_written[i])
				return 1'b1;
		for (e = 0; e < table_count; e++)
			for (i = 0; i < len; i++)
				if (!table_written[e*MAX_DIM + i])
					return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [ELEM_W-1:0] rand_elem();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic stim_row_t cfg_row(input int v);
		stim_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.flen = FLEN_W'(v);
		return r;
	endfunction

	function automatic stim_row_t item_row(input logic [MODE_W-1:0] m,
			input logic [ELEM_W-1:0] v, input logic [LABEL_W-1:0] l);
		stim_row_t r;
		r = '{default: '0};
		r.item = '{m, v, l};
		return r;
	endfunction

	function automatic stim_row_t want_row(input logic [MODE_W-1:0] m,
			input logic [ELEM_W-1:0] v, input logic f, input logic [LABEL_W-1:0] bl,
			input logic [DIST_W-1:0] bd);
		stim_row_t r;
		r = item_row(m, v, '0);
		r.typed = 1'b1;
		r.want = '{f, bl, bd};
		return r;
	endfunction

	// Offers one item, waits for its acceptance and records what it owes.
	// A query end that would read unwritten store data is turned into a clear.
	task automatic drive_item(input nnc_in_t it, input bit typed = 1'b0,
			input nnc_out_t want = '0);
		int gap;
		nnc_out_t res;
		if (reads_unwritten(it))
			it.mode = MODE_CLEAR;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			query_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		query_ch.valid <= 1'b1;
		query_ch.data <= it;
		do @(posedge clk); while (!query_ch.ready);
		if (classify_item(it, res))
			pending_results.insert(pending_results.size(), typed ? want : res);
	endtask

	// Stops offering items until every owed result has arrived.
	task automatic settle();
		@(negedge clk);
		query_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_length(input int v);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= FLEN_W'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
		feature_len = FLEN_W'(v);
	endtask

	// Sends a whole vector; a near query copies a stored entry with small noise.
	task automatic send_vector(input logic [MODE_W-1:0] m, input bit near);
		int len;
		int e;
		int i;
		logic [ELEM_W-1:0] v;
		logic [ELEM_W-1:0] delta;
		len = active_len();
		e = (table_count > 0) ? $urandom_range(0, table_count - 1) : 0;
		delta = ($urandom_range(0, 2) == 0) ? '0 : ELEM_W'($urandom_range(0, 6)) - 16'd3;
		for (i = 0; i < len; i++) begin
			if (near && table_count > 0)
				v = table_elems[e*MAX_DIM + i] + delta;
			else
				v = rand_elem();
			drive_item('{m, v, LABEL_W'($urandom)});
		end
	endtask

	// One random phase at a given register value. Mostly whole load and query
	// vectors, with single stray items that break sequences.
	task automatic run_phase(input int flen_val, input int budget, input int cap,
			input bit fill);
		int sent;
		int pick;
		logic [MODE_W-1:0] m;
		set_length(flen_val);
		drive_item('{MODE_CLEAR, rand_elem(), LABEL_W'($urandom)});
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 9);
			if (fill && table_count < MAX_ENTRIES)
				pick = 0;
			if (pick < 5 && (fill || table_count < cap)) begin
				send_vector(MODE_LOAD, 1'b0);
				sent += active_len();
			end else if (pick < 9) begin
				send_vector(MODE_QUERY, $urandom_range(0, 1));
				sent += active_len();
			end else begin
				m = MODE_W'($urandom_range(0, 3));
				if (m == MODE_CLEAR && $urandom_range(0, 2) != 0)
					m = MODE_UNUSED;
				drive_item('{m, rand_elem(), LABEL_W'($urandom)});
				sent++;
			end
		end
	endtask

	// Result side: random stalls, plus one long hold on request.
	initial begin : result_sink
		int gap;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				result_ch.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 8);
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
				result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each accepted result item with the oldest owed result.
	always @(posedge clk) begin : result_check
		nnc_out_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with none owed: found=%0d label=%0h dist=%0d",
					result_ch.data.found, result_ch.data.nearest_label,
					result_ch.data.best_distance_sq);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_ch.data.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found,
						result_ch.data.found);
					mismatch_count++;
				end
				if (result_ch.data.nearest_label !== want.nearest_label) begin
					$error("nearest_label: expected %0h, got %0h", want.nearest_label,
						result_ch.data.nearest_label);
					mismatch_count++;
				end
				if (result_ch.data.best_distance_sq !== want.best_distance_sq) begin
					$error("best_distance_sq: expected %0d, got %0d",
						want.best_distance_sq, result_ch.data.best_distance_sq);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog.
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		query_ch.valid = 1'b0;
		query_ch.data = '0;
		mismatch_count = 0;
		idle_on = 1'b1;
		hold_request = 1'b0;
		table_count = 0;
		vec_pos = 0;
		feature_len = FEATURE_LENGTH_RESET;
		foreach (table_written[i])
			table_written[i] = 1'b0;
		foreach (probe_written[i])
			probe_written[i] = 1'b0;

		// Extremes, ties, clear, unused code, length folding, a length that
		// shrinks mid-vector and a vector that mixes load and query.
		directed = '{
			cfg_row(1),
			want_row(MODE_QUERY, 16'h1234, 1'b0, 16'h0000, '0),
			item_row(MODE_LOAD, 16'h7FFF, 16'hFFFF),
			item_row(MODE_LOAD, 16'h8000, 16'h0000),
			want_row(MODE_QUERY, 16'h8000, 1'b1, 16'h0000, '0),
			want_row(MODE_QUERY, 16'h7FFF, 1'b1, 16'hFFFF, '0),
			item_row(MODE_UNUSED, 16'h5A5A, 16'hA5A5),
			item_row(MODE_LOAD, 16'h0000, 16'h1234),
			item_row(MODE_QUERY, 16'h0001, 16'h0000),
			item_row(MODE_LOAD, 16'h0000, 16'h5678),
			want_row(MODE_QUERY, 16'h0000, 1'b1, 16'h1234, '0),
			item_row(MODE_CLEAR, 16'h0000, 16'h0000),
			want_row(MODE_QUERY, 16'h1111, 1'b0, 16'h0000, '0),
			cfg_row(0),
			item_row(MODE_LOAD, 16'h0100, 16'h0007),
			want_row(MODE_QUERY, 16'h0100, 1'b1, 16'h0007, '0),
			cfg_row(4),
			item_row(MODE_CLEAR, 16'h0000, 16'h0000),
			item_row(MODE_LOAD, 16'h0200, 16'hAAAA),
			item_row(MODE_LOAD, 16'hFF00, 16'hAAAA),
			cfg_row(2),
			item_row(MODE_LOAD, 16'h0300, 16'h5555),
			item_row(MODE_QUERY, 16'h0200, 16'h0000),
			item_row(MODE_QUERY, 16'h0300, 16'h0000),
			item_row(MODE_LOAD, 16'h0000, 16'h9999),
			want_row(MODE_QUERY, 16'h0300, 1'b1, 16'h5555, '0)
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[r]) begin
			if (directed[r].is_cfg)
				set_length(directed[r].flen);
			else
				drive_item(directed[r].item, directed[r].typed, directed[r].want);
		end

		run_phase(3, 50, 8, 1'b0);
		run_phase(0, 30, 6, 1'b0);
		// Long result stall while single-element queries keep coming.
		hold_request = 1'b1;
		repeat (30)
			drive_item('{MODE_QUERY, rand_elem(), LABEL_W'($urandom)});
		run_phase(1, 275, 0, 1'b1);
		run_phase(127, 64, 2, 1'b0);
		run_phase(5, 30, 10, 1'b0);
		idle_on = 1'b0;
		run_phase(64, 128, 1, 1'b0);

		@(negedge clk);
		query_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
